[hw/rtl/bqe_pkg.sv]
// ----------------------------------------------------------------------------
// bqe_pkg
// Types and fixed constants shared by the biquad cascade equalizer modules.
// ----------------------------------------------------------------------------
package bqe_pkg;

  // field widths fixed by the item format
  localparam int SAMPLE_BITS = 24;   // Q1.23 samples
  localparam int COEF_BITS   = 32;   // Q4.28 coefficients
  localparam int FRAC_SHIFT  = COEF_BITS - 4;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  // five exact products plus the rounding constant
  localparam int ACC_W       = PROD_W + 3;

  localparam int NUM_TAPS = 5;

  // action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // coefficient slots inside one band
  localparam logic [2:0] TAP_B0 = 3'd0;
  localparam logic [2:0] TAP_B1 = 3'd1;
  localparam logic [2:0] TAP_B2 = 3'd2;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_A2 = 3'd4;

  typedef struct packed {
    logic                          action;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [2:0]                    band;
    logic [2:0]                    coef_slot;
    logic signed [COEF_BITS-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic                          channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } out_item_t;

  // history of one band for one channel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_row_t;

  typedef struct packed {
    logic clear;   // load accumulator with the rounding constant
    logic mul_en;  // take a product this cycle
    logic neg;     // product is subtracted (feedback taps)
  } mac_ctrl_t;

endpackage

[hw/rtl/biquad_cascade_equalizer.sv]
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer
// Per-channel cascade of direct-form-I biquad bands on one shared MAC unit.
// ----------------------------------------------------------------------------
// A filter beat runs through the bands in turn: each band reads its history
// row and first coefficient (READ), feeds the five taps to the single 24x32
// multiplier (MAC), drains the last product (DRAIN), then rounds, saturates
// and writes the history back (WRITE); after the last band the result is
// handed to the output register (DONE). The input is stalled for that whole
// time, and the hand-over waits while an earlier result sits unaccepted in
// the output register. A load beat writes the coefficient memory directly.
// After reset the coefficient and history memories are zeroed by a sweep
// over max(5*BANDS, BANDS*CHANNELS) entries with the input stalled. A
// finished result sits in an output register, so the next beat can be taken
// while it waits.
module biquad_cascade_equalizer import bqe_pkg::*; #(
  parameter int BANDS    = 6,
  parameter int CHANNELS = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int COEF_N  = BANDS * NUM_TAPS;
  localparam int ROWS    = BANDS * CHANNELS;
  localparam int CLR_N   = (COEF_N > ROWS) ? COEF_N : ROWS;
  localparam int COEF_AW = $clog2(COEF_N);
  localparam int CIDX_W  = $clog2(COEF_N + 1);
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_d, state_q;
  logic [CLR_W-1:0] clr_d, clr_q;
  logic [CIDX_W-1:0] cidx_d, cidx_q;
  logic [2:0] tap_d, tap_q;
  logic [BAND_W-1:0] band_d, band_q;
  logic [ROW_AW-1:0] row_d, row_q;
  logic ch_d, ch_q;
  logic signed [SAMPLE_BITS-1:0] x_d, x_q;

  logic signed [COEF_BITS-1:0] coef_mem [COEF_N];
  hist_row_t                   hist_mem [ROWS];
  logic signed [COEF_BITS-1:0] coef_rd_q;
  hist_row_t                   hist_rd_q;

  logic in_take;
  logic ld_ok;
  logic ch_ok;
  logic coef_re;
  logic coef_we;
  logic [COEF_AW-1:0] coef_waddr;
  logic signed [COEF_BITS-1:0] coef_wdata;
  logic hist_we;
  logic [ROW_AW-1:0] hist_waddr;
  hist_row_t hist_wdata;

  mac_ctrl_t mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_smp;
  logic signed [SAMPLE_BITS-1:0] mac_y;

  logic out_valid_d, out_valid_q;
  out_item_t out_data_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign ld_ok      = (32'(in_data_i.band) < BANDS) && (32'(in_data_i.coef_slot) < NUM_TAPS);
  assign ch_ok      = (32'(in_data_i.channel) < CHANNELS);

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cidx_d  = cidx_q;
    tap_d   = tap_q;
    band_d  = band_q;
    row_d   = row_q;
    ch_d    = ch_q;
    x_d     = x_q;
    coef_re = 1'b0;
    mac_ctrl = '0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take && in_data_i.action == ACT_FILTER && ch_ok) begin
          state_d = ST_READ;
          cidx_d  = '0;
          band_d  = '0;
          row_d   = ROW_AW'(in_data_i.channel);
          ch_d    = in_data_i.channel;
          x_d     = in_data_i.sample_in;
        end
      end
      ST_READ: begin
        coef_re        = 1'b1;
        cidx_d         = cidx_q + CIDX_W'(1);
        tap_d          = TAP_B0;
        mac_ctrl.clear = 1'b1;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.neg    = (tap_q >= TAP_A1);
        tap_d           = tap_q + 3'd1;
        if (tap_q == TAP_A2) begin
          state_d = ST_DRAIN;
        end else begin
          coef_re = 1'b1;
          cidx_d  = cidx_q + CIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        x_d    = mac_y;
        band_d = band_q + BAND_W'(1);
        row_d  = row_q + ROW_AW'(CHANNELS);
        if (band_q == BAND_W'(BANDS - 1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (tap_q)
      TAP_B0:  mac_smp = x_q;
      TAP_B1:  mac_smp = hist_rd_q.x1;
      TAP_B2:  mac_smp = hist_rd_q.x2;
      TAP_A1:  mac_smp = hist_rd_q.y1;
      TAP_A2:  mac_smp = hist_rd_q.y2;
      default: mac_smp = x_q;
    endcase
  end

  bqe_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .smp_i  (mac_smp),
    .coef_i (coef_rd_q),
    .y_o    (mac_y)
  );

  // memory write ports: clearing sweep, coefficient loads, history update
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = COEF_AW'(32'(in_data_i.band) * NUM_TAPS + 32'(in_data_i.coef_slot));
    coef_wdata = in_data_i.coef_value;
    hist_we    = 1'b0;
    hist_waddr = row_q;
    hist_wdata.x1 = x_q;
    hist_wdata.x2 = hist_rd_q.x1;
    hist_wdata.y1 = mac_y;
    hist_wdata.y2 = hist_rd_q.y1;
    if (state_q == ST_CLEAR) begin
      coef_we    = (32'(clr_q) < COEF_N);
      coef_waddr = clr_q[COEF_AW-1:0];
      coef_wdata = '0;
      hist_we    = (32'(clr_q) < ROWS);
      hist_waddr = clr_q[ROW_AW-1:0];
      hist_wdata = '0;
    end else if (state_q == ST_WRITE) begin
      hist_we = 1'b1;
    end else if (in_take && in_data_i.action == ACT_LOAD && ld_ok) begin
      coef_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (coef_re) begin
      coef_rd_q <= coef_mem[cidx_q[COEF_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (state_q == ST_READ) begin
      hist_rd_q <= hist_mem[row_q];
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_data_q.channel_out <= ch_q;
      out_data_q.sample_out  <= x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cidx_q      <= '0;
      tap_q       <= '0;
      band_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cidx_q      <= cidx_d;
      tap_q       <= tap_d;
      band_q      <= band_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    x_q  <= x_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result only appears after the cascade has finished
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("result raised without a finished cascade");

  // every band rounds only after its last product has drained
  a_write_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q) == ST_DRAIN)
    else $error("band written back before accumulation finished");

  // all coefficients of the cascade were read exactly once
  a_all_coefs_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && $past(state_q) == ST_WRITE) |-> cidx_q == CIDX_W'(COEF_N))
    else $error("coefficient read count wrong at end of cascade");

  // tap counter stays within one band
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> tap_q <= TAP_A2)
    else $error("tap counter out of range");

endmodule

[hw/rtl/bqe_mac.sv]
// ----------------------------------------------------------------------------
// bqe_mac
// Shared multiply-accumulate unit with round-half-up and saturation to the
// sample format. One registered product per cycle, accumulated in the next cycle.
// ----------------------------------------------------------------------------
module bqe_mac import bqe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     neg_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  shr;

  assign prod_d = smp_i * coef_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = RND;
    end else if (pv_q) begin
      if (neg_q) begin
        acc_d = acc_q - ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= ctrl_i.neg;
    end
    acc_q <= acc_d;
  end

  assign shr = acc_q >>> FRAC_SHIFT;

  always_comb begin
    if (shr > SAT_HI) begin
      y_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shr < SAT_LO) begin
      y_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_o = shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

[dv/tb_biquad_cascade_equalizer.sv]
// ----------------------------------------------------------------------------
// tb_biquad_cascade_equalizer
// Self-checking bench for the six-band biquad cascade. Coefficient loads and
// samples are driven through the valid/stall input, and every filtered beat
// is checked against a stated result or the fixed-point cascade model kept in
// the bench. A short directed table covers reset state, extremes and ignored
// loads. Random traffic with random gaps and output stalls follows.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_equalizer import bqe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS_N         = 6;
  localparam int CHANS_N         = 2;
  localparam int RANDOM_ITEMS    = 950;
  localparam int RETUNE_EVERY    = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 120;
  localparam int CYCLE_LIMIT     = 800000;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  // 1.0 in Q4.28
  localparam logic signed [COEF_BITS-1:0]   C_ONE = 32'sh1000_0000;
  localparam longint SAT_HI = longint'(S_MAX);
  localparam longint SAT_LO = longint'(S_MIN);

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // bench copy of the coefficient memory and band histories
  logic signed [COEF_BITS-1:0]   coef_mem [BANDS_N][NUM_TAPS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] x_hist [BANDS_N][CHANS_N][2] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] y_hist [BANDS_N][CHANS_N][2] = '{default: '0};

  out_item_t pending_outputs[$];
  dir_row_t  dir_rows[$];
  int        fail_count = 0;
  int        sent_count = 0;
  int        cycle_count = 0;
  bit        hold_off_req = 1'b0;
  bit        hold_off_done = 1'b0;

  biquad_cascade_equalizer #(
    .BANDS    (BANDS_N),
    .CHANNELS (CHANS_N)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // loads update the table, samples run through all bands and give one beat
  task automatic cascade_accept(input in_item_t b, output bit has_res, output out_item_t res);
    longint acc;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    int ch;
    has_res = 1'b0;
    res = '0;
    if (b.action == ACT_LOAD) begin
      if (b.band < BANDS_N && b.coef_slot < NUM_TAPS)
        coef_mem[b.band][b.coef_slot] = b.coef_value;
      return;
    end
    ch = int'(b.channel);
    if (ch >= CHANS_N) return;
    x = b.sample_in;
    for (int bi = 0; bi < BANDS_N; bi++) begin
      acc = longint'(coef_mem[bi][TAP_B0]) * longint'(x)
          + longint'(coef_mem[bi][TAP_B1]) * longint'(x_hist[bi][ch][0])
          + longint'(coef_mem[bi][TAP_B2]) * longint'(x_hist[bi][ch][1])
          - longint'(coef_mem[bi][TAP_A1]) * longint'(y_hist[bi][ch][0])
          - longint'(coef_mem[bi][TAP_A2]) * longint'(y_hist[bi][ch][1])
          + (longint'(1) <<< (FRAC_SHIFT - 1));
      acc = acc >>> FRAC_SHIFT;
      if (acc > SAT_HI) y = S_MAX;
      else if (acc < SAT_LO) y = S_MIN;
      else y = acc[SAMPLE_BITS-1:0];
      x_hist[bi][ch][1] = x_hist[bi][ch][0];
      x_hist[bi][ch][0] = x;
      y_hist[bi][ch][1] = y_hist[bi][ch][0];
      y_hist[bi][ch][0] = y;
      x = y;
    end
    res.channel_out = b.channel;
    res.sample_out  = x;
    has_res = 1'b1;
  endtask

  function automatic in_item_t mk_filter(bit ch, logic signed [SAMPLE_BITS-1:0] s);
    in_item_t b;
    b = '0;
    b.action    = ACT_FILTER;
    b.channel   = ch;
    b.sample_in = s;
    return b;
  endfunction

  function automatic in_item_t mk_load(logic [2:0] bnd, logic [2:0] slot,
                                       logic signed [COEF_BITS-1:0] v);
    in_item_t b;
    b.action     = ACT_LOAD;
    b.channel    = 1'b1;
    b.sample_in  = 24'h5a5a5a;
    b.band       = bnd;
    b.coef_slot  = slot;
    b.coef_value = v;
    return b;
  endfunction

  function automatic out_item_t mk_result(bit ch, logic signed [SAMPLE_BITS-1:0] s);
    out_item_t r;
    r.channel_out = ch;
    r.sample_out  = s;
    return r;
  endfunction

  function automatic void add_row(in_item_t b, bit typed = 1'b0, out_item_t want = '0);
    dir_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic int draw_gap();
    int r;
    // every third window of beats goes back to back
    if ((sent_count / 80) % 3 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
    bit has_res;
    out_item_t res;
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cascade_accept(b, has_res, res);
    if (has_res) pending_outputs.push_back(typed ? want : res);
    sent_count++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t random_beat();
    in_item_t b;
    int r;
    b = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 72) begin
      b.action = ACT_FILTER;
      if ($urandom_range(0, 9) < 3)
        b.sample_in = SAMPLE_BITS'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
    end else if (r < 94) begin
      b.action    = ACT_LOAD;
      b.band      = 3'($urandom_range(0, BANDS_N - 1));
      b.coef_slot = 3'($urandom_range(0, NUM_TAPS - 1));
      r = $urandom_range(0, 9);
      if (r < 5) b.coef_value = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      else if (r < 7) b.coef_value = (b.coef_slot == TAP_B0) ? C_ONE : '0;
    end else begin
      // loads aimed past the table are dropped
      b.action = ACT_LOAD;
      if ($urandom_range(0, 1)) b.band = 3'($urandom_range(BANDS_N, 7));
      else b.coef_slot = 3'($urandom_range(NUM_TAPS, 7));
    end
    return b;
  endfunction

  initial begin : stimulus
    in_item_t b;
    logic signed [COEF_BITS-1:0] v;
    int rnd_sent;

    add_row(mk_filter(1'b0, S_MAX), 1'b1, mk_result(1'b0, '0));
    b = {$urandom, $urandom};
    b.action = ACT_FILTER;
    b.channel = 1'b1;
    b.sample_in = S_MIN;
    b.band = 3'b111;
    b.coef_slot = 3'b111;
    b.coef_value = '1;
    add_row(b, 1'b1, mk_result(1'b1, '0));
    for (int bi = 0; bi < BANDS_N; bi++) add_row(mk_load(3'(bi), TAP_B0, C_ONE));
    add_row(mk_filter(1'b0, S_MAX), 1'b1, mk_result(1'b0, S_MAX));
    add_row(mk_filter(1'b1, S_MIN), 1'b1, mk_result(1'b1, S_MIN));
    add_row(mk_load(3'd6, TAP_B0, C_MAX));
    add_row(mk_load(3'd7, TAP_B0, '0));
    add_row(mk_load(3'd0, 3'd5, C_MAX));
    add_row(mk_load(3'd0, 3'd7, '0));
    add_row(mk_filter(1'b0, 24'sd12345), 1'b1, mk_result(1'b0, 24'sd12345));
    // band 0 at its gain limits drives the cascade into saturation
    add_row(mk_load(3'd0, TAP_B0, C_MAX));
    add_row(mk_filter(1'b0, S_MAX), 1'b1, mk_result(1'b0, S_MAX));
    add_row(mk_filter(1'b1, S_MIN), 1'b1, mk_result(1'b1, S_MIN));
    add_row(mk_load(3'd0, TAP_B0, C_MIN));
    add_row(mk_filter(1'b0, S_MIN), 1'b1, mk_result(1'b0, S_MAX));
    add_row(mk_load(3'd0, TAP_B0, C_ONE));
    add_row(mk_load(3'd1, TAP_A1, -C_ONE));
    add_row(mk_load(3'd2, TAP_B1, 32'sh0800_0000));
    add_row(mk_load(3'd3, TAP_A2, 32'sh0400_0000));
    add_row(mk_load(3'd4, TAP_B2, -32'sh0200_0000));
    add_row(mk_filter(1'b0, 24'sd1000));
    add_row(mk_filter(1'b0, -24'sd3000));
    add_row(mk_filter(1'b1, 24'sd777));

    wait (rst_ni);
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      pause_sender(draw_gap());
    end

    hold_off_req = 1'b1;
    rnd_sent = 0;
    while (rnd_sent < RANDOM_ITEMS) begin
      if (rnd_sent % RETUNE_EVERY == 0) begin
        // retune every band to a mild curve so outputs do not sit on the rails
        for (int bi = 0; bi < BANDS_N; bi++) begin
          for (int s = 0; s < NUM_TAPS; s++) begin
            v = int'($urandom_range(0, 1 << 26)) - (1 << 25);
            if (s == TAP_B0) v = v + C_ONE;
            send_beat(mk_load(3'(bi), 3'(s), v), 1'b0, '0);
            pause_sender(draw_gap());
          end
        end
        rnd_sent += BANDS_N * NUM_TAPS;
      end else begin
        send_beat(random_beat(), 1'b0, '0);
        pause_sender(draw_gap());
        rnd_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : output_stall
    int run;
    int hold;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long hold-off so the block fills and stalls its input
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        hold = $urandom_range(0, 99);
        run = (hold < 70) ? $urandom_range(1, 4) :
              (hold < 90) ? $urandom_range(5, 30) : $urandom_range(50, 200);
        out_stall_i <= 1'b0;
        repeat (run) @(posedge clk_i);
        hold = $urandom_range(0, 99);
        hold = (hold < 40) ? 0 : (hold < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result beat: channel_out %0d sample_out %0d",
               out_data_o.channel_out, out_data_o.sample_out);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_data_o.channel_out !== want.channel_out) begin
          $error("channel_out mismatch: expected %0d actual %0d",
                 want.channel_out, out_data_o.channel_out);
          fail_count++;
        end
        if (out_data_o.sample_out !== want.sample_out) begin
          $error("sample_out mismatch: expected %0d actual %0d",
                 want.sample_out, out_data_o.sample_out);
          fail_count++;
        end
      end
    end
  end

endmodule

[biquad_cascade_equalizer.f]
hw/rtl/bqe_pkg.sv
hw/rtl/bqe_mac.sv
hw/rtl/biquad_cascade_equalizer.sv
dv/tb_biquad_cascade_equalizer.sv
